@@ hw/rtl/kpm_pkg.sv @@
// Package for the key press merger: sizes, controller states and command/status types.
package kpm_pkg;

	localparam int KPM_TABLE_ENTRIES = 16;
	localparam int KPM_HOLDER_BITS   = 8;
	localparam int KPM_CODE_W        = 10;
	localparam int KPM_IN_TDATA_W    = 16;
	localparam int KPM_OUT_TDATA_W   = 8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_UPDATE
	} kpm_state_t;

	typedef struct packed {
		logic start;
		logic scan;
		logic update;
	} kpm_cmd_t;

	typedef struct packed {
		logic last_addr;
		logic out_full;
	} kpm_status_t;

endpackage

@@ hw/rtl/key_press_merger.sv @@
// Top level of the key press merger: stream ports, controller, datapath and checks.
// Each key event item passes through the controller states in order: idle, in which the
// item is accepted, a scan that reads one table entry per cycle from the single-port
// keycode and holder memories, a last state that finishes the last compare, and an
// update that writes the table and loads the result register; the next item is taken
// in idle again. The result register drives the output. A held result that is not
// taken stalls the update. The block handles one item at a time; the table starts
// empty after reset with no clearing pass.
module key_press_merger import kpm_pkg::*; #(
	parameter int TABLE_ENTRIES = KPM_TABLE_ENTRIES,
	parameter int HOLDER_BITS   = KPM_HOLDER_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [KPM_IN_TDATA_W-1:0]  s_tdata,  // [9:0] key_code, rest zero
	input  logic                       s_tuser,  // [0] is_press
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [KPM_OUT_TDATA_W-1:0] m_tdata   // [0] forward, [1] table_full, rest zero
);

	kpm_cmd_t    cmd;
	kpm_status_t status;
	kpm_state_t  state;
	logic        forward;
	logic        table_full;

	kpm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd),
		.state    (state)
	);

	kpm_datapath #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.HOLDER_BITS   (HOLDER_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.key_code   (s_tdata[KPM_CODE_W-1:0]),
		.is_press   (s_tuser),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.forward    (forward),
		.table_full (table_full)
	);

	assign m_tdata = {{(KPM_OUT_TDATA_W - 2){1'b0}}, table_full, forward};

	a_result_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
		else $error("result both forwarded and flagged as table full");

	a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("new item accepted while a scan is under way");

	a_result_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state == ST_UPDATE))
		else $error("result appeared without an update cycle");

endmodule

@@ hw/rtl/kpm_datapath.sv @@
// Datapath of the key press merger: held-key table, scan compare and result register.
module kpm_datapath import kpm_pkg::*; #(
	parameter int TABLE_ENTRIES = KPM_TABLE_ENTRIES,
	parameter int HOLDER_BITS   = KPM_HOLDER_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  kpm_cmd_t                   cmd,
	output kpm_status_t                status,
	input  logic [KPM_CODE_W-1:0]      key_code,
	input  logic                       is_press,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       forward,
	output logic                       table_full
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [KPM_CODE_W-1:0]    code_mem [TABLE_ENTRIES];
	logic [HOLDER_BITS-1:0]   hold_mem [TABLE_ENTRIES];

	logic [KPM_CODE_W-1:0]    code_q;
	logic                     press_q;
	logic [IDX_W-1:0]         scan_idx_q;

	logic                     cmp_en_s1;
	logic                     rd_valid_s1;
	logic [KPM_CODE_W-1:0]    rd_code_s1;
	logic [HOLDER_BITS-1:0]   rd_hold_s1;
	logic [IDX_W-1:0]         rd_idx_s1;

	logic                     hit_q;
	logic [IDX_W-1:0]         hit_idx_q;
	logic [HOLDER_BITS-1:0]   hit_hold_q;
	logic                     free_q;
	logic [IDX_W-1:0]         free_idx_q;

	logic                     out_valid_q;
	logic                     forward_q;
	logic                     full_q;

	logic                     wr_code_en;
	logic                     wr_hold_en;
	logic [IDX_W-1:0]         wr_idx;
	logic [HOLDER_BITS-1:0]   wr_hold;
	logic                     set_valid;
	logic                     clr_valid;
	logic                     res_forward;
	logic                     res_full;

	always_comb begin
		wr_code_en  = 1'b0;
		wr_hold_en  = 1'b0;
		wr_idx      = hit_idx_q;
		wr_hold     = hit_hold_q;
		set_valid   = 1'b0;
		clr_valid   = 1'b0;
		res_forward = 1'b0;
		res_full    = 1'b0;
		if (hit_q) begin
			if (press_q) begin
				if (hit_hold_q != '1) begin
					wr_hold_en = 1'b1;
					wr_hold    = hit_hold_q + HOLDER_BITS'(1);
				end
			end else if (hit_hold_q > HOLDER_BITS'(1)) begin
				wr_hold_en = 1'b1;
				wr_hold    = hit_hold_q - HOLDER_BITS'(1);
			end else begin
				clr_valid   = 1'b1;
				res_forward = 1'b1;
			end
		end else if (!press_q) begin
			res_forward = 1'b1;
		end else if (!free_q) begin
			res_full = 1'b1;
		end else begin
			wr_idx      = free_idx_q;
			wr_code_en  = 1'b1;
			wr_hold_en  = 1'b1;
			wr_hold     = HOLDER_BITS'(1);
			set_valid   = 1'b1;
			res_forward = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update && wr_code_en) begin
			code_mem[wr_idx] <= code_q;
		end
		if (cmd.update && wr_hold_en) begin
			hold_mem[wr_idx] <= wr_hold;
		end
		if (cmd.scan) begin
			rd_code_s1 <= code_mem[scan_idx_q];
			rd_hold_s1 <= hold_mem[scan_idx_q];
			rd_valid_s1 <= valid_q[scan_idx_q];
			rd_idx_s1 <= scan_idx_q;
		end
		if (cmd.start) begin
			code_q  <= key_code;
			press_q <= is_press;
		end
		if (cmd.update) begin
			forward_q <= res_forward;
			full_q    <= res_full;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			scan_idx_q  <= '0;
			cmp_en_s1   <= 1'b0;
			hit_q       <= 1'b0;
			hit_idx_q   <= '0;
			hit_hold_q  <= '0;
			free_q      <= 1'b0;
			free_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			cmp_en_s1 <= cmd.scan;
			if (cmd.start) begin
				scan_idx_q <= '0;
				hit_q      <= 1'b0;
				free_q     <= 1'b0;
			end else begin
				if (cmd.scan && scan_idx_q != LAST_IDX) begin
					scan_idx_q <= scan_idx_q + IDX_W'(1);
				end
				if (cmp_en_s1) begin
					if (rd_valid_s1) begin
						if (!hit_q && rd_code_s1 == code_q) begin
							hit_q      <= 1'b1;
							hit_idx_q  <= rd_idx_s1;
							hit_hold_q <= rd_hold_s1;
						end
					end else if (!free_q) begin
						free_q     <= 1'b1;
						free_idx_q <= rd_idx_s1;
					end
				end
			end
			if (cmd.update && set_valid) begin
				valid_q[wr_idx] <= 1'b1;
			end
			if (cmd.update && clr_valid) begin
				valid_q[wr_idx] <= 1'b0;
			end
			if (cmd.update) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.last_addr = (scan_idx_q == LAST_IDX);
	assign status.out_full  = out_valid_q && !out_ready;
	assign out_valid  = out_valid_q;
	assign forward    = forward_q;
	assign table_full = full_q;

endmodule

@@ hw/rtl/kpm_ctrl.sv @@
// Controller of the key press merger: sequences the table scan and the update.
module kpm_ctrl import kpm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  kpm_status_t status,
	output kpm_cmd_t    cmd,
	output kpm_state_t  state
);

	kpm_state_t state_q;
	kpm_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (status.last_addr) begin
					state_d = ST_LAST;
				end
			end
			ST_LAST: begin
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (!status.out_full) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.start = in_valid;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
			end
			ST_UPDATE: begin
				cmd.update = !status.out_full;
			end
			default: begin
			end
		endcase
	end

	assign state = state_q;

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the key press merger: directed table, saturation run and random traffic.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import kpm_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int LONG_HOLD   = 400;
	localparam int RANDOM_ITEMS = 150;
	localparam int POOL_SIZE   = 24;
	localparam logic [KPM_HOLDER_BITS-1:0] HOLDER_MAX = '1;

	typedef struct packed {
		logic forward;
		logic table_full;
	} key_verdict_t;

	typedef struct packed {
		logic [KPM_CODE_W-1:0] code;
		logic                  press;
		logic                  typed;
		logic                  forward;
		logic                  table_full;
	} key_row_t;

	localparam int ROWS = 25;
	localparam key_row_t KEY_ROWS [ROWS] = '{
		'{10'd0,    1'b0, 1'b1, 1'b1, 1'b0},
		'{10'd0,    1'b1, 1'b1, 1'b1, 1'b0},
		'{10'd1023, 1'b1, 1'b1, 1'b1, 1'b0},
		'{10'd1023, 1'b1, 1'b1, 1'b0, 1'b0},
		'{10'd1023, 1'b0, 1'b1, 1'b0, 1'b0},
		'{10'd1023, 1'b0, 1'b1, 1'b1, 1'b0},
		'{10'd1023, 1'b0, 1'b1, 1'b1, 1'b0},
		'{10'd1,    1'b1, 1'b1, 1'b1, 1'b0},
		'{10'd2,    1'b1, 1'b1, 1'b1, 1'b0},
		'{10'd4,    1'b1, 1'b1, 1'b1, 1'b0},
		'{10'd8,    1'b1, 1'b1, 1'b1, 1'b0},
		'{10'd16,   1'b1, 1'b1, 1'b1, 1'b0},
		'{10'd32,   1'b1, 1'b1, 1'b1, 1'b0},
		'{10'd64,   1'b1, 1'b1, 1'b1, 1'b0},
		'{10'd128,  1'b1, 1'b1, 1'b1, 1'b0},
		'{10'd256,  1'b1, 1'b1, 1'b1, 1'b0},
		'{10'd512,  1'b1, 1'b1, 1'b1, 1'b0},
		'{10'd341,  1'b1, 1'b1, 1'b1, 1'b0},
		'{10'd682,  1'b1, 1'b1, 1'b1, 1'b0},
		'{10'd100,  1'b1, 1'b1, 1'b1, 1'b0},
		'{10'd200,  1'b1, 1'b1, 1'b1, 1'b0},
		'{10'd1023, 1'b1, 1'b1, 1'b1, 1'b0},
		'{10'd999,  1'b1, 1'b1, 1'b0, 1'b1},
		'{10'd0,    1'b0, 1'b1, 1'b1, 1'b0},
		'{10'd999,  1'b1, 1'b0, 1'b0, 1'b0}
	};

	logic                       clk;
	logic                       arst_n   = 1'b0;
	logic                       s_tvalid = 1'b0;
	logic                       s_tready;
	logic [KPM_IN_TDATA_W-1:0]  s_tdata  = '0;  // [9:0] key_code, rest zero
	logic                       s_tuser  = 1'b0; // [0] is_press
	logic                       m_tvalid;
	logic                       m_tready = 1'b0;
	logic [KPM_OUT_TDATA_W-1:0] m_tdata;        // [0] forward, [1] table_full, rest zero

	logic                       held_valid [KPM_TABLE_ENTRIES];
	logic [KPM_CODE_W-1:0]      held_code  [KPM_TABLE_ENTRIES];
	logic [KPM_HOLDER_BITS-1:0] held_count [KPM_TABLE_ENTRIES];

	key_verdict_t expected_verdicts [$];
	int  mismatches   = 0;
	int  results_seen = 0;
	int  idle_cycles  = 0;
	int  burst_left   = 0;
	bit  long_hold_req = 1'b0;

	key_press_merger dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic key_verdict_t merge_key_event(logic [KPM_CODE_W-1:0] code, logic press);
		int hit;
		int free_idx;
		key_verdict_t v;
		hit = -1;
		free_idx = -1;
		v = '0;
		for (int i = 0; i < KPM_TABLE_ENTRIES; i++) begin
			if (held_valid[i]) begin
				if (hit < 0 && held_code[i] == code)
					hit = i;
			end else if (free_idx < 0) begin
				free_idx = i;
			end
		end
		if (hit >= 0) begin
			if (press) begin
				if (held_count[hit] != HOLDER_MAX)
					held_count[hit] = held_count[hit] + 1'b1;
			end else if (held_count[hit] > 1) begin
				held_count[hit] = held_count[hit] - 1'b1;
			end else begin
				held_count[hit] = '0;
				held_valid[hit] = 1'b0;
				v.forward = 1'b1;
			end
		end else if (!press) begin
			v.forward = 1'b1;
		end else if (free_idx < 0) begin
			v.table_full = 1'b1;
		end else begin
			held_valid[free_idx] = 1'b1;
			held_code[free_idx]  = code;
			held_count[free_idx] = KPM_HOLDER_BITS'(1);
			v.forward = 1'b1;
		end
		return v;
	endfunction

	task automatic report_mismatch(string field, int unsigned want, int unsigned seen);
		$display("%0t: result %0d, %s expected %0d, got %0d", $time, results_seen, field, want, seen);
		mismatches++;
	endtask

	task automatic send_key_event(logic [KPM_CODE_W-1:0] code, logic press, bit use_typed,
			key_verdict_t typed_verdict);
		int gap;
		key_verdict_t v;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
			burst_left = $urandom_range(1, 20);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= KPM_IN_TDATA_W'(code);
		s_tuser  <= press;
		do @(posedge clk); while (!(s_tvalid && s_tready));
		v = merge_key_event(code, press);
		expected_verdicts.push_back(use_typed ? typed_verdict : v);
		burst_left--;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_verdicts.size() != 0);
	endtask

	initial begin
		int unsigned roll;
		int pick;
		int held_idx [$];
		logic [KPM_CODE_W-1:0] code_pool [POOL_SIZE];
		for (int i = 0; i < KPM_TABLE_ENTRIES; i++) begin
			held_valid[i] = 1'b0;
			held_code[i]  = '0;
			held_count[i] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (KEY_ROWS[r])
			send_key_event(KEY_ROWS[r].code, KEY_ROWS[r].press, KEY_ROWS[r].typed,
				'{KEY_ROWS[r].forward, KEY_ROWS[r].table_full});

		repeat (256) send_key_event(10'd999, 1'b1, 1'b0, '0);
		repeat (3) send_key_event(10'd999, 1'b0, 1'b0, '0);
		wait_drained();

		for (int i = 0; i < KPM_TABLE_ENTRIES; i++)
			if (held_valid[i] && held_count[i] == KPM_HOLDER_BITS'(1))
				send_key_event(held_code[i], 1'b0, 1'b0, '0);

		foreach (code_pool[i])
			code_pool[i] = KPM_CODE_W'($urandom_range(0, 1023));
		long_hold_req = 1'b1;
		burst_left = 60;

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 2)
				wait_drained();
			if ($urandom_range(0, 29) == 0)
				code_pool[$urandom_range(0, POOL_SIZE - 1)] = KPM_CODE_W'($urandom_range(0, 1023));
			roll = $urandom_range(0, 99);
			held_idx.delete();
			for (int i = 0; i < KPM_TABLE_ENTRIES; i++)
				if (held_valid[i])
					held_idx.push_back(i);
			if (roll < 8) begin
				send_key_event(KPM_CODE_W'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)),
					1'b0, '0);
			end else if (roll < 53) begin
				send_key_event(code_pool[$urandom_range(0, POOL_SIZE - 1)], 1'b1, 1'b0, '0);
			end else if (roll < 93 && held_idx.size() != 0) begin
				pick = held_idx[$urandom_range(0, held_idx.size() - 1)];
				send_key_event(held_code[pick], 1'b0, 1'b0, '0);
			end else begin
				send_key_event(code_pool[$urandom_range(0, POOL_SIZE - 1)], 1'b0, 1'b0, '0);
			end
		end

		wait_drained();
		repeat (40) @(posedge clk);
		if (expected_verdicts.size() != 0)
			report_mismatch("outstanding results", 0, 32'(expected_verdicts.size()));
		if (mismatches == 0) begin
			$display("key_press_merger: match");
		end else begin
			$display("key_press_merger: mismatch");
		end
		$finish;
	end

	initial begin
		int mode;
		int seg_left;
		int phase;
		mode = 0;
		seg_left = 50;
		phase = 0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD - 1) @(posedge clk);
			end else begin
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= (phase % 4 == 0);
					default: m_tready <= ($urandom_range(0, 9) != 0);
				endcase
				phase++;
				seg_left--;
				if (seg_left == 0) begin
					mode = $urandom_range(0, 3);
					seg_left = $urandom_range(20, 200);
				end
			end
		end
	end

	always @(posedge clk) begin
		key_verdict_t want;
		if (m_tvalid && m_tready) begin
			if (expected_verdicts.size() == 0) begin
				report_mismatch("unexpected result, tdata", 0, 32'(m_tdata));
			end else begin
				want = expected_verdicts.pop_front();
				if (m_tdata[0] !== want.forward)
					report_mismatch("forward", 32'(want.forward), 32'(m_tdata[0]));
				if (m_tdata[1] !== want.table_full)
					report_mismatch("table_full", 32'(want.table_full), 32'(m_tdata[1]));
				if (m_tdata[KPM_OUT_TDATA_W-1:2] !== '0)
					report_mismatch("tdata padding", 0, 32'(m_tdata[KPM_OUT_TDATA_W-1:2]));
			end
			results_seen++;
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("key_press_merger: mismatch");
				$finish;
			end
		end
	end

endmodule
